/* rtl/core/sli_pkg.sv */
// Shared constants and codes for the sorted list intersection unit.
package sli_pkg;

   localparam int LIST_DEPTH  = 16;
   localparam int VALUE_WIDTH = 32;

   localparam int IN_VALUE_W  = 32;
   localparam int OUT_VALUE_W = 32;
   localparam int MODE_W      = 2;
   localparam int COUNT_W     = 5;
   localparam int STATUS_W    = 2;

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int LEN_W = $clog2(LIST_DEPTH + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT_A  = 2'd0,
      MODE_INSERT_B  = 2'd1,
      MODE_INTERSECT = 2'd2,
      MODE_CLEAR     = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

endpackage

/* rtl/core/sli_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module sli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/sorted_list_intersection_unit.sv */
// Sorted list intersection unit: two bounded ascending signed lists, insert, intersect and clear.
//
// The unit holds two ascending lists A and B of up to LIST_DEPTH signed values each, every
// list in its own RAM with one read and one write port. One request is worked at a time and
// req_ready is high only while the unit is idle. An insert into an empty list writes the value
// in ST_INS_RD. Otherwise ST_INS_CMP moves each entry greater than the new value up a place
// and then writes the value, in ST_INS_PUT if all entries moved. A full list is not written.
// Each insert gives one response. An intersect walks both lists one compare per cycle unless
// a match waits for the output register. It gives one response per common value (or one
// empty-status response), the last one flagged by rsp_last. A clear empties both lists and
// gives no response. Responses sit in an output register; a stalled rsp_ready holds the walk
// until the register frees up.
module sorted_list_intersection_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sli_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [sli_pkg::IN_VALUE_W-1:0] req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [sli_pkg::OUT_VALUE_W-1:0] rsp_value_res,
   output logic [sli_pkg::COUNT_W-1:0]          rsp_count,
   output logic [sli_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                 rsp_last
);

   import sli_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_INS_DONE,
      ST_ISX_RD,
      ST_ISX_CMP,
      ST_ISX_END
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_W-1:0] len_a_ff, len_a_in;
   logic [LEN_W-1:0] len_b_ff, len_b_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] p_ff, p_in;
   logic [LEN_W-1:0] q_ff, q_in;
   logic [LEN_W-1:0] k_ff, k_in;
   logic             sel_b_ff, sel_b_in;
   logic             full_ff, full_in;
   logic             pend_ff, pend_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic signed [VALUE_WIDTH-1:0] pend_val_ff, pend_val_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]             rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0]            rsp_status_ff, rsp_status_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                          out_free;
   logic                          req_xfer;
   logic [LEN_W-1:0]              cur_len;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;
   logic [IDX_W-1:0]              rd_addr_a;
   logic [IDX_W-1:0]              rd_addr_b;
   logic signed [VALUE_WIDTH-1:0] rd_a;
   logic signed [VALUE_WIDTH-1:0] rd_b;
   logic signed [VALUE_WIDTH-1:0] rd_sel;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer = req_valid && req_ready;
   assign cur_len = sel_b_ff ? len_b_ff : len_a_ff;
   assign rd_sel = sel_b_ff ? rd_b : rd_a;

   always_comb begin
      state_in      = state_ff;
      len_a_in      = len_a_ff;
      len_b_in      = len_b_ff;
      idx_in        = idx_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      k_in          = k_ff;
      sel_b_in      = sel_b_ff;
      full_in       = full_ff;
      pend_in       = pend_ff;
      key_in        = key_ff;
      pend_val_in   = pend_val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_data       = key_ff;
      rd_addr_a     = p_ff[IDX_W-1:0];
      rd_addr_b     = q_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               key_in = VALUE_WIDTH'(req_value);
               case (mode_type'(req_mode))
                  MODE_INSERT_A, MODE_INSERT_B: begin
                     sel_b_in = (mode_type'(req_mode) == MODE_INSERT_B);
                     idx_in   = sel_b_in ? len_b_ff : len_a_ff;
                     full_in  = (idx_in >= LEN_W'(LIST_DEPTH));
                     state_in = full_in ? ST_INS_DONE : ST_INS_RD;
                  end
                  MODE_INTERSECT: begin
                     p_in     = '0;
                     q_in     = '0;
                     k_in     = '0;
                     pend_in  = 1'b0;
                     state_in = ST_ISX_RD;
                  end
                  default: begin
                     len_a_in = '0;
                     len_b_in = '0;
                  end
               endcase
            end
         end

         ST_INS_RD: begin
            rd_addr_a = IDX_W'(idx_ff - LEN_W'(1));
            rd_addr_b = rd_addr_a;
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               state_in = ST_INS_DONE;
            end else begin
               state_in = ST_INS_CMP;
            end
         end

         ST_INS_CMP: begin
            rd_addr_a = IDX_W'(idx_ff - LEN_W'(2));
            rd_addr_b = rd_addr_a;
            wr_en     = 1'b1;
            if (rd_sel > key_ff) begin
               wr_data  = rd_sel;
               idx_in   = idx_ff - LEN_W'(1);
               state_in = (idx_ff == LEN_W'(1)) ? ST_INS_PUT : ST_INS_CMP;
            end else begin
               state_in = ST_INS_DONE;
            end
         end

         ST_INS_PUT: begin
            wr_en    = 1'b1;
            state_in = ST_INS_DONE;
         end

         ST_INS_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_last_in  = 1'b1;
               if (full_ff) begin
                  rsp_count_in  = COUNT_W'(cur_len);
                  rsp_status_in = STATUS_FULL;
               end else begin
                  rsp_count_in  = COUNT_W'(cur_len + LEN_W'(1));
                  rsp_status_in = STATUS_OK;
                  if (sel_b_ff) begin
                     len_b_in = len_b_ff + LEN_W'(1);
                  end else begin
                     len_a_in = len_a_ff + LEN_W'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end

         ST_ISX_RD: begin
            state_in = (len_a_ff != '0 && len_b_ff != '0) ? ST_ISX_CMP : ST_ISX_END;
         end

         ST_ISX_CMP: begin
            if (rd_a == rd_b) begin
               if (!pend_ff || out_free) begin
                  if (pend_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = OUT_VALUE_W'(pend_val_ff);
                     rsp_count_in  = COUNT_W'(k_ff);
                     rsp_status_in = STATUS_OK;
                     rsp_last_in   = 1'b0;
                  end
                  pend_in     = 1'b1;
                  pend_val_in = rd_a;
                  k_in        = k_ff + LEN_W'(1);
                  p_in        = p_ff + LEN_W'(1);
                  q_in        = q_ff + LEN_W'(1);
               end
            end else if (rd_a < rd_b) begin
               p_in = p_ff + LEN_W'(1);
            end else begin
               q_in = q_ff + LEN_W'(1);
            end
            rd_addr_a = p_in[IDX_W-1:0];
            rd_addr_b = q_in[IDX_W-1:0];
            if (p_in >= len_a_ff || q_in >= len_b_ff) begin
               state_in = ST_ISX_END;
            end
         end

         ST_ISX_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (pend_ff) begin
                  rsp_value_in  = OUT_VALUE_W'(pend_val_ff);
                  rsp_count_in  = COUNT_W'(k_ff);
                  rsp_status_in = STATUS_OK;
               end else begin
                  rsp_value_in  = '0;
                  rsp_count_in  = '0;
                  rsp_status_in = STATUS_EMPTY;
               end
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      k_ff          <= k_in;
      sel_b_ff      <= sel_b_in;
      full_ff       <= full_in;
      key_ff        <= key_in;
      pend_val_ff   <= pend_val_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   sli_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (LIST_DEPTH)
   ) u_list_a (
      .clock   (clock),
      .wr_en   (wr_en && !sel_b_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   sli_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (LIST_DEPTH)
   ) u_list_b (
      .clock   (clock),
      .wr_en   (wr_en && sel_b_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_a_ff <= LEN_W'(LIST_DEPTH) && len_b_ff <= LEN_W'(LIST_DEPTH))
      else $error("list length beyond depth");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISX_CMP |-> (p_ff < len_a_ff && q_ff < len_b_ff))
      else $error("intersect walk past list end");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_mode == MODE_CLEAR |=> (len_a_ff == '0 && len_b_ff == '0))
      else $error("clear left entries");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_EMPTY |-> (rsp_last_ff && rsp_count_ff == '0))
      else $error("empty response malformed");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_FULL |-> rsp_count_ff == COUNT_W'(LIST_DEPTH))
      else $error("full response with wrong count");

endmodule
